// ===== design/mexp_pkg.sv =====
// Shared constants and types for the modular exponentiation unit.
// No dependencies; every other design file depends on this package.
package mexp_pkg;

	localparam int MODULUS_BITS = 31;
	localparam int BASE_BITS    = 31;
	localparam int EXP_BITS     = 63;
	localparam int CNT_BITS     = $clog2(BASE_BITS);

	localparam logic [MODULUS_BITS-1:0] MOD_RESET = MODULUS_BITS'(1000000007);

	typedef logic [BASE_BITS-1:0] opnd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_DECIDE,
		ST_MUL_ACC,
		ST_MUL_SQ
	} mexp_state_t;

endpackage

// ===== design/mexp_in_if.sv =====
// Request channel of the modular exponentiation unit: valid/ready plus payload.
// Depends on mexp_pkg for field widths.
interface mexp_in_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [mexp_pkg::BASE_BITS-1:0] base_value;
	logic [mexp_pkg::EXP_BITS-1:0]  exponent;

	modport source (output valid, mode, base_value, exponent, input ready);
	modport sink   (input valid, mode, base_value, exponent, output ready);
endinterface

// ===== design/mexp_out_if.sv =====
// Result channel of the modular exponentiation unit: valid/ready plus payload.
// Depends on mexp_pkg for field widths.
interface mexp_out_if;
	logic                           valid;
	logic                           ready;
	logic [mexp_pkg::BASE_BITS-1:0] result;

	modport source (output valid, result, input ready);
	modport sink   (input valid, result, output ready);
endinterface

// ===== design/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: base^exponent mod modulus by square-and-multiply.
// Depends on mexp_pkg, mexp_in_if and mexp_out_if.
//
// Usage:
//   req carries mode, base_value and exponent; rsp carries result. A beat moves
//   when valid and ready are both high. mode 1 replaces the exponent by
//   modulus-2 (Fermat inverse for a prime modulus). The user must write the
//   modulus register through cfg_we/cfg_wdata only while the unit is idle;
//   the unit itself does not enforce this. A single shared modular multiplier
//   works MSB first over one operand, one bit per cycle. The base is first
//   reduced with that same multiplier. Each exponent bit then passes a
//   decision step, a multiply into the accumulator when the bit is set, and
//   a squaring unless it is the top bit.
//   req.ready is high only while no item is in work, so the next request is
//   taken in the cycle in which rsp.valid rises at the earliest.
//   A modulus below two skips the arithmetic; its result passes through the
//   decision step into the output register. A zero exponent still pays for
//   the base reduction.
//   The result sits in an output register, so a new request is taken while
//   rsp is stalled; a finished item waits in its decision step until the
//   output register frees.
//   Reset (arst_n low) empties the unit and sets the modulus to 1000000007.
module modular_exponentiation_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mexp_pkg::MODULUS_BITS-1:0] cfg_wdata,
	mexp_in_if.sink                           req,
	mexp_out_if.source                        rsp
);
	import mexp_pkg::*;

	mexp_state_t state_q, state_d;

	logic [MODULUS_BITS-1:0] mod_q;
	opnd_t                   base_q;
	logic [EXP_BITS-1:0]     exp_q;
	opnd_t                   acc_q;
	opnd_t                   sq_q;
	opnd_t                   r_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic                    rsp_valid_q;
	opnd_t                   rsp_data_q;

	logic                    accept;
	logic                    mod_small;
	opnd_t                   mw;
	opnd_t                   op_a;
	opnd_t                   op_b;
	logic                    bit_b;
	logic [BASE_BITS+1:0]    t;
	logic [BASE_BITS+2:0]    d1;
	logic [BASE_BITS+2:0]    d2;
	opnd_t                   r_next;
	logic                    last;
	logic                    out_free;
	logic                    unit_busy;
	logic                    start;
	logic                    acc_we;
	logic                    sq_we;
	logic                    exp_shift;
	logic                    out_load;

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign mod_small  = (mod_q < MODULUS_BITS'(2));
	assign mw         = BASE_BITS'(mod_q);
	assign last       = (cnt_q == '0);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = rsp_data_q;

	// Shared multiplier step: r = (2r + bit*a) mod m, with 2r + a < 3m.
	always_comb begin
		unique case (state_q)
			ST_REDUCE: begin
				op_a = BASE_BITS'(1);
				op_b = base_q;
			end
			ST_MUL_ACC: begin
				op_a = sq_q;
				op_b = acc_q;
			end
			default: begin
				op_a = sq_q;
				op_b = sq_q;
			end
		endcase
		bit_b = op_b[cnt_q];
		t     = {1'b0, r_q, 1'b0} + (bit_b ? {2'b00, op_a} : '0);
		d1    = {1'b0, t} - {3'b000, mw};
		d2    = {1'b0, t} - {2'b00, mw, 1'b0};
		priority if (!d2[BASE_BITS+2]) begin
			r_next = d2[BASE_BITS-1:0];
		end else if (!d1[BASE_BITS+2]) begin
			r_next = d1[BASE_BITS-1:0];
		end else begin
			r_next = t[BASE_BITS-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		unit_busy = 1'b0;
		start     = 1'b0;
		acc_we    = 1'b0;
		sq_we     = 1'b0;
		exp_shift = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					start   = 1'b1;
					state_d = mod_small ? ST_DECIDE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				unit_busy = 1'b1;
				if (last) begin
					sq_we   = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (exp_q == '0) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (exp_q[0]) begin
					start   = 1'b1;
					state_d = ST_MUL_ACC;
				end else begin
					start   = 1'b1;
					state_d = ST_MUL_SQ;
				end
			end
			ST_MUL_ACC: begin
				unit_busy = 1'b1;
				if (last) begin
					acc_we = 1'b1;
					// skip the squaring after the top exponent bit
					if (exp_q[EXP_BITS-1:1] != '0) begin
						start   = 1'b1;
						state_d = ST_MUL_SQ;
					end else begin
						exp_shift = 1'b1;
						state_d   = ST_DECIDE;
					end
				end
			end
			ST_MUL_SQ: begin
				unit_busy = 1'b1;
				if (last) begin
					sq_we     = 1'b1;
					exp_shift = 1'b1;
					state_d   = ST_DECIDE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mod_q       <= MOD_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= req.base_value;
			acc_q  <= mod_small ? '0 : BASE_BITS'(1);
			priority if (mod_small) begin
				exp_q <= '0;
			end else if (req.mode) begin
				exp_q <= EXP_BITS'(mod_q) - EXP_BITS'(2);
			end else begin
				exp_q <= req.exponent;
			end
		end else begin
			if (acc_we) begin
				acc_q <= r_next;
			end
			if (exp_shift) begin
				exp_q <= {1'b0, exp_q[EXP_BITS-1:1]};
			end
		end
		if (sq_we) begin
			sq_q <= r_next;
		end
		if (start) begin
			r_q   <= '0;
			cnt_q <= CNT_BITS'(BASE_BITS - 1);
		end else if (unit_busy) begin
			r_q   <= r_next;
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
		if (out_load) begin
			rsp_data_q <= acc_q;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for modular_exponentiation_unit: power and Fermat-inverse requests
// under several modulus settings, results compared with a square-and-multiply predictor.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and the unit itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	localparam logic MODE_POWER   = 1'b0;
	localparam logic MODE_INVERSE = 1'b1;
	localparam int   CYCLE_LIMIT  = 4_000_000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [MODULUS_BITS-1:0] cfg_wdata;

	mexp_in_if  req_if ();
	mexp_out_if rsp_if ();

	modular_exponentiation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	opnd_t                   pending_results[$];
	opnd_t                   want;
	logic [MODULUS_BITS-1:0] modulus_now = MOD_RESET;
	int                      burst_left      = 0;
	int                      items_sent      = 0;
	int                      inverse_sent    = 0;
	int                      results_checked = 0;
	int                      settings_count  = 0;
	int                      fail_count      = 0;
	int                      cycle_count     = 0;

	always #5ns clk = ~clk;

	// base^power mod m by square-and-multiply; every product stays below 2^62
	function automatic opnd_t power_mod(input logic mode, input opnd_t base,
			input logic [EXP_BITS-1:0] power, input logic [MODULUS_BITS-1:0] m);
		logic [63:0]         acc;
		logic [63:0]         sq;
		logic [63:0]         mm;
		logic [EXP_BITS-1:0] e;
		mm = 64'(m);
		if (mm < 64'd2)
			return '0;
		e   = (mode == MODE_INVERSE) ? EXP_BITS'(mm - 64'd2) : power;
		acc = 64'd1;
		sq  = 64'(base) % mm;
		while (e != '0) begin
			if (e[0])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
			e  = e >> 1;
		end
		return opnd_t'(acc);
	endfunction

	task automatic send_request(input logic mode, input opnd_t base,
			input logic [EXP_BITS-1:0] power);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 12);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 6);
		end
		burst_left--;
		req_if.valid      <= 1'b1;
		req_if.mode       <= mode;
		req_if.base_value <= base;
		req_if.exponent   <= power;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		pending_results = {pending_results, power_mod(mode, base, power, modulus_now)};
		items_sent++;
		if (mode == MODE_INVERSE)
			inverse_sent++;
	endtask

	// hold off until every outstanding result has been taken
	task automatic drain_unit;
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_modulus(input logic [MODULUS_BITS-1:0] value);
		drain_unit();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		modulus_now = value;
		settings_count++;
	endtask

	task automatic test_reset_modulus;
		send_request(MODE_POWER, '0, '0);
		send_request(MODE_POWER, '0, '1);
		send_request(MODE_POWER, '1, '1);
		send_request(MODE_POWER, opnd_t'(2), EXP_BITS'(10));
		send_request(MODE_POWER, opnd_t'(MOD_RESET), EXP_BITS'(3));
		send_request(MODE_INVERSE, opnd_t'(2), '0);
		send_request(MODE_INVERSE, '1, '1);
		send_request(MODE_INVERSE, '0, EXP_BITS'(5));
	endtask

	task automatic test_modulus_extremes;
		// modulus two: inverse power is zero
		set_modulus(MODULUS_BITS'(2));
		send_request(MODE_INVERSE, opnd_t'(5), '1);
		send_request(MODE_POWER, '1, '1);
		send_request(MODE_POWER, opnd_t'(4), EXP_BITS'(1));
		set_modulus('1);
		send_request(MODE_INVERSE, opnd_t'(3), '0);
		send_request(MODE_INVERSE, '1, '0);
		send_request(MODE_POWER, opnd_t'(31'h7FFF_FFFE), '1);
		// degenerate moduli give zero in both modes
		set_modulus('0);
		send_request(MODE_POWER, opnd_t'(5), EXP_BITS'(7));
		send_request(MODE_INVERSE, opnd_t'(9), '0);
		set_modulus(MODULUS_BITS'(1));
		send_request(MODE_POWER, '0, '0);
		send_request(MODE_INVERSE, opnd_t'(7), EXP_BITS'(3));
		// composite modulus: inverse mode is not a true inverse
		set_modulus(MODULUS_BITS'(1_000_000));
		send_request(MODE_INVERSE, opnd_t'(10), '0);
		send_request(MODE_INVERSE, opnd_t'(999_999), '0);
	endtask

	task automatic test_random_traffic;
		logic [MODULUS_BITS-1:0] m;
		logic [EXP_BITS-1:0]     power;
		opnd_t                   base;
		logic                    mode;
		int                      n;
		int                      sel;
		int                      width;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: m = MOD_RESET;
				1: m = '1;
				2: m = MODULUS_BITS'($urandom_range(2, 255));
				3: m = MODULUS_BITS'($urandom);
				4: m = MODULUS_BITS'(998_244_353);
				5: m = MODULUS_BITS'($urandom_range(0, 1));
				default: m = MODULUS_BITS'(3 * $urandom_range(1000, 700_000_000));
			endcase
			set_modulus(m);
			n = (phase == 5) ? 8 : 19;
			repeat (n) begin
				mode = ($urandom_range(0, 3) == 0) ? MODE_INVERSE : MODE_POWER;
				sel  = $urandom_range(0, 9);
				case (sel)
					0: base = '0;
					1: base = opnd_t'(m * $urandom_range(1, 2));
					2: base = opnd_t'($urandom_range(1, 20));
					default: base = opnd_t'($urandom);
				endcase
				// keep most exponents short; a few use the full width
				sel   = $urandom_range(0, 9);
				width = (sel < 7) ? $urandom_range(0, 12)
					: (sel < 9) ? $urandom_range(13, 32) : EXP_BITS;
				power = EXP_BITS'({$urandom, $urandom});
				if (width < EXP_BITS)
					power = power & ((EXP_BITS'(1) << width) - EXP_BITS'(1));
				send_request(mode, base, power);
			end
		end
	endtask

	// receiver: long ready runs, choppy stretches and long stalls
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			case ($urandom_range(0, 3))
				0: begin
					rsp_if.ready <= 1'b1;
					repeat ($urandom_range(100, 600)) @(posedge clk);
				end
				1: begin
					repeat ($urandom_range(10, 40)) begin
						rsp_if.ready <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
				end
				2: begin
					rsp_if.ready <= 1'b0;
					repeat ($urandom_range(20, 120)) @(posedge clk);
				end
				default: begin
					rsp_if.ready <= 1'b1;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$display("%0t: result %0d with no request outstanding", $time, rsp_if.result);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.result !== want) begin
					$display("%0t: result mismatch, expected %0d, actual %0d",
						$time, want, rsp_if.result);
					fail_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results outstanding",
			$time, cycle_count, pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		req_if.valid      <= 1'b0;
		req_if.mode       <= MODE_POWER;
		req_if.base_value <= '0;
		req_if.exponent   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_modulus();
		test_modulus_extremes();
		test_random_traffic();
		drain_unit();
		// catch any stray result after the last one expected
		repeat (64) @(posedge clk);
		$display("Sent %0d requests (%0d inverse) across %0d modulus writes;",
			items_sent, inverse_sent, settings_count);
		$display("checked %0d results, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/mexp_pkg.sv
design/mexp_in_if.sv
design/mexp_out_if.sv
design/modular_exponentiation_unit.sv
tb/tb_top.sv
